[rtl/core/bct_pkg.sv]
`default_nettype none
package bct_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int COORD_BITS = 12;
  localparam int ISUM_BITS  = 32;
  localparam int WSUM_BITS  = 44;
  localparam int PROD_BITS  = PIXEL_BITS + COORD_BITS;
  localparam int CNT_BITS   = $clog2(WSUM_BITS);

  localparam logic [ISUM_BITS-1:0] THRESH_RESET = ISUM_BITS'(100);

  typedef struct packed {
    logic [ISUM_BITS-1:0] isum;
    logic [WSUM_BITS-1:0] xsum;
    logic [WSUM_BITS-1:0] ysum;
  } moments_t;

  typedef struct packed {
    logic acc_en;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic                 start;
    logic [WSUM_BITS-1:0] dividend;
    logic [ISUM_BITS-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic [COORD_BITS-1:0] quotient;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_DIVX = 5'b00100,
    ST_DIVY = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

[rtl/core/blob_centroid_tracker.sv]
// pixels are taken one per cycle while a frame is being accumulated
// after the frame-end pixel: a threshold check state; if no object, ready again next cycle
// if found: two 44-step divisions on one shared bit-serial divider, then an output state
// in_tready low until the result is loaded, longer while the previous result waits; out_tvalid then
// rises. Synchronous active-low reset clears the moment sums, stored point, valid flags and
// sets the area threshold to 100
`default_nettype none
module blob_centroid_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // pixel_value[7:0], column[19:8], row[31:20]
  input  wire logic        in_tlast,   // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // centroid_x, centroid_y, previous_x, previous_y
  output logic             out_tuser,  // previous_valid
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  bct_pkg::state_t                state_r;
  bct_pkg::state_t                state_nxt;
  logic [bct_pkg::ISUM_BITS-1:0]  thr_r;
  logic [bct_pkg::COORD_BITS-1:0] cx_r;
  logic [bct_pkg::COORD_BITS-1:0] last_x_r;
  logic [bct_pkg::COORD_BITS-1:0] last_y_r;
  logic                           last_valid_r;
  logic                           out_valid_r;
  logic [47:0]                    out_data_r;
  logic                           out_user_r;
  logic                           in_fire;
  logic                           found;
  logic                           out_load;
  bct_pkg::acc_ctrl_t             acc_ctrl;
  bct_pkg::moments_t              moments;
  bct_pkg::div_ctrl_t             div_ctrl;
  bct_pkg::div_stat_t             div_stat;

  assign in_tready = (state_r == bct_pkg::ST_ACC);
  assign in_fire   = in_tvalid && in_tready;
  assign found     = moments.isum > thr_r;
  assign out_load  = (state_r == bct_pkg::ST_OUT) && (!out_valid_r || out_tready);

  bct_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (acc_ctrl),
    .pixel   (in_tdata[7:0]),
    .col     (in_tdata[19:8]),
    .row     (in_tdata[31:20]),
    .moments (moments)
  );

  bct_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  always_comb begin
    state_nxt         = state_r;
    acc_ctrl.acc_en   = in_fire;
    acc_ctrl.clear    = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = (state_r == bct_pkg::ST_CHK) ? moments.xsum : moments.ysum;
    div_ctrl.divisor  = moments.isum;
    case (state_r)
      bct_pkg::ST_ACC: begin
        if (in_fire && in_tlast) begin
          state_nxt = bct_pkg::ST_CHK;
        end
      end
      bct_pkg::ST_CHK: begin
        if (found) begin
          div_ctrl.start = 1'b1;
          state_nxt      = bct_pkg::ST_DIVX;
        end else begin
          acc_ctrl.clear = 1'b1;
          state_nxt      = bct_pkg::ST_ACC;
        end
      end
      bct_pkg::ST_DIVX: begin
        if (div_stat.done) begin
          div_ctrl.start = 1'b1;
          state_nxt      = bct_pkg::ST_DIVY;
        end
      end
      bct_pkg::ST_DIVY: begin
        if (div_stat.done) begin
          acc_ctrl.clear = 1'b1;
          state_nxt      = bct_pkg::ST_OUT;
        end
      end
      bct_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = bct_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = bct_pkg::ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bct_pkg::ST_ACC;
      thr_r        <= bct_pkg::THRESH_RESET;
      last_x_r     <= '0;
      last_y_r     <= '0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (out_load) begin
        last_x_r     <= cx_r;
        last_y_r     <= div_stat.quotient;
        last_valid_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cy stays on the divider output until the next start
  always_ff @(posedge clk) begin
    if (state_r == bct_pkg::ST_DIVX && div_stat.done) begin
      cx_r <= div_stat.quotient;
    end
    if (out_load) begin
      out_data_r <= {last_y_r, last_x_r, div_stat.quotient, cx_r};
      out_user_r <= last_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

[rtl/core/bct_accum.sv]
`default_nettype none
module bct_accum (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bct_pkg::acc_ctrl_t              ctrl,
  input  wire logic [bct_pkg::PIXEL_BITS-1:0]  pixel,
  input  wire logic [bct_pkg::COORD_BITS-1:0]  col,
  input  wire logic [bct_pkg::COORD_BITS-1:0]  row,
  output bct_pkg::moments_t                    moments
);

  bct_pkg::moments_t                  mom_r;
  bct_pkg::moments_t                  mom_nxt;
  logic [bct_pkg::PROD_BITS-1:0]      prod_x;
  logic [bct_pkg::PROD_BITS-1:0]      prod_y;
  logic [bct_pkg::ISUM_BITS:0]        isum_add;
  logic [bct_pkg::WSUM_BITS:0]        xsum_add;
  logic [bct_pkg::WSUM_BITS:0]        ysum_add;

  always_comb begin
    prod_x = {{bct_pkg::COORD_BITS{1'b0}}, pixel} * {{bct_pkg::PIXEL_BITS{1'b0}}, col};
    prod_y = {{bct_pkg::COORD_BITS{1'b0}}, pixel} * {{bct_pkg::PIXEL_BITS{1'b0}}, row};
    isum_add = {1'b0, mom_r.isum}
             + {{(bct_pkg::ISUM_BITS + 1 - bct_pkg::PIXEL_BITS){1'b0}}, pixel};
    xsum_add = {1'b0, mom_r.xsum}
             + {{(bct_pkg::WSUM_BITS + 1 - bct_pkg::PROD_BITS){1'b0}}, prod_x};
    ysum_add = {1'b0, mom_r.ysum}
             + {{(bct_pkg::WSUM_BITS + 1 - bct_pkg::PROD_BITS){1'b0}}, prod_y};
    mom_nxt = mom_r;
    if (ctrl.clear) begin
      mom_nxt = '0;
    end else if (ctrl.acc_en) begin
      // saturate on carry out
      mom_nxt.isum = isum_add[bct_pkg::ISUM_BITS] ? '1 : isum_add[bct_pkg::ISUM_BITS-1:0];
      mom_nxt.xsum = xsum_add[bct_pkg::WSUM_BITS] ? '1 : xsum_add[bct_pkg::WSUM_BITS-1:0];
      mom_nxt.ysum = ysum_add[bct_pkg::WSUM_BITS] ? '1 : ysum_add[bct_pkg::WSUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_r <= '0;
    end else begin
      mom_r <= mom_nxt;
    end
  end

  assign moments = mom_r;

endmodule
`default_nettype wire

[rtl/core/bct_divider.sv]
`default_nettype none
module bct_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bct_pkg::div_ctrl_t ctrl,
  output bct_pkg::div_stat_t      stat
);

  logic                          busy_r;
  logic                          busy_nxt;
  logic                          done_r;
  logic                          done_nxt;
  logic [bct_pkg::CNT_BITS-1:0]  cnt_r;
  logic [bct_pkg::CNT_BITS-1:0]  cnt_nxt;
  logic [bct_pkg::ISUM_BITS-1:0] rem_r;
  logic [bct_pkg::ISUM_BITS-1:0] rem_nxt;
  logic [bct_pkg::WSUM_BITS-1:0] quo_r;
  logic [bct_pkg::WSUM_BITS-1:0] quo_nxt;
  logic [bct_pkg::ISUM_BITS:0]   trial;
  logic [bct_pkg::ISUM_BITS:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[bct_pkg::WSUM_BITS-1]};
    diff     = trial - {1'b0, ctrl.divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = ctrl.dividend;
    end else if (busy_r) begin
      if (!diff[bct_pkg::ISUM_BITS]) begin
        rem_nxt = diff[bct_pkg::ISUM_BITS-1:0];
      end else begin
        rem_nxt = trial[bct_pkg::ISUM_BITS-1:0];
      end
      quo_nxt = {quo_r[bct_pkg::WSUM_BITS-2:0], ~diff[bct_pkg::ISUM_BITS]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bct_pkg::CNT_BITS'(bct_pkg::WSUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quotient = (|quo_r[bct_pkg::WSUM_BITS-1:bct_pkg::COORD_BITS]) ? '1
                         : quo_r[bct_pkg::COORD_BITS-1:0];

endmodule
`default_nettype wire
